// ----- design/srpc_pkg.sv -----
// Shared types and constants for the stepper ramp position controller.
`default_nettype none
package srpc_pkg;

  localparam int unsigned PosW      = 25;
  localparam int unsigned IntervalW = 20;
  localparam int unsigned ElapsedW  = 21;

  localparam logic [PosW-1:0]      PosMostNeg   = 25'h1000000;
  localparam logic [PosW-1:0]      PosNegLimit  = 25'h1000001;
  localparam logic [IntervalW-1:0] RampStart    = 20'd5000;
  localparam logic [IntervalW-1:0] RampDownStep = 20'd20;
  localparam logic [IntervalW-1:0] SlowCeiling  = 20'd2500;
  localparam logic [IntervalW-1:0] SlowUpStep   = 20'd100;
  localparam logic [PosW:0]        NearDistance = 26'd100;
  localparam logic [IntervalW-1:0] IntervalRst  = 20'd10000;

  typedef enum logic [1:0] {
    CMD_TICK = 2'd0,
    CMD_GOTO = 2'd1,
    CMD_STOP = 2'd2,
    CMD_SET  = 2'd3
  } cmd_e;

  typedef enum logic {
    REG_STEP_INTERVAL = 1'b0,
    REG_INVERT        = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic                  we;
    reg_idx_e              index;
    logic [IntervalW-1:0]  data;
  } cfg_wr_t;

  typedef struct packed {
    logic                  moving;
    logic signed [PosW-1:0] target_position;
    logic signed [PosW-1:0] current_position;
    logic                  dir_pin_level;
    logic                  move_negative;
    logic                  step_taken;
  } result_t;

endpackage
`default_nettype wire

// ----- design/stepper_ramp_position_controller_core.sv -----
// Top level of the stepper ramp position controller.
// Input stream: s_axis_tuser carries the command (tick, goto, stop, set),
// s_axis_tdata carries the position used by goto and set. One item is taken per
// cycle while s_axis_tready is high; each tick item stands for one microsecond.
// Output stream: exactly one result item per input item, giving the step
// pulse, its direction, the direction pin level, current and target position
// and the moving flag.
// The motion state and the output buffer update at the edge that accepts the
// item; the result goes to the result register, or to the skid register if one waits.
// Throughput is one item per cycle while s_axis_tready is high.
// A two-entry output buffer lets an item be accepted while a result waits;
// when both entries are full, s_axis_tready drops until the receiver takes one.
// Configuration writes (cfg_we_i, cfg_index_i, cfg_data_i) take effect at the
// next edge: index 0 is the cruise step interval, index 1 the output inversion.
// Reset clears positions, timer and direction, loads ramp interval 5000,
// step interval 10000 and no inversion, and empties the output buffer.
`default_nettype none
module stepper_ramp_position_controller_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_index_i,
  input  wire logic [19:0] cfg_data_i,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,  // [24:0] position, [31:25] zero
  input  wire logic [1:0]  s_axis_tuser,  // [1:0] command
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [0] step_taken, [1] move_negative, [2] dir_pin_level,
  // [27:3] current_position, [52:28] target_position, [53] moving, [55:54] zero
  output logic [55:0]      m_axis_tdata
);
  import srpc_pkg::*;

  cfg_wr_t cfg;
  result_t core_result;
  result_t out_result;
  logic    accept;

  assign cfg.we    = cfg_we_i;
  assign cfg.index = reg_idx_e'(cfg_index_i);
  assign cfg.data  = cfg_data_i;

  assign accept = s_axis_tvalid && s_axis_tready;

  srpc_step_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .accept_i   (accept),
    .command_i  (s_axis_tuser),
    .position_i (s_axis_tdata[PosW-1:0]),
    .result_o   (core_result)
  );

  srpc_out_buf u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept),
    .data_i      (core_result),
    .ready_o     (s_axis_tready),
    .valid_o     (m_axis_tvalid),
    .pop_ready_i (m_axis_tready),
    .data_o      (out_result)
  );

  assign m_axis_tdata = {2'b00, out_result.moving, out_result.target_position,
                         out_result.current_position, out_result.dir_pin_level,
                         out_result.move_negative, out_result.step_taken};

endmodule
`default_nettype wire

// ----- design/srpc_step_core.sv -----
// Motion state, configuration registers and per-item step/ramp update.
`default_nettype none
module srpc_step_core (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire srpc_pkg::cfg_wr_t             cfg_i,
  input  wire logic                          accept_i,
  input  wire logic [1:0]                    command_i,
  input  wire logic [srpc_pkg::PosW-1:0]     position_i,
  output srpc_pkg::result_t                  result_o
);
  import srpc_pkg::*;

  logic [IntervalW-1:0]   step_interval_q;
  logic                   invert_q;
  logic signed [PosW-1:0] pos_now_q, pos_now_d;
  logic signed [PosW-1:0] pos_goal_q, pos_goal_d;
  logic [IntervalW-1:0]   ramp_q, ramp_d;
  logic [ElapsedW-1:0]    elapsed_q, elapsed_d;
  logic                   last_dir_q, last_dir_d;

  cmd_e                   cmd;
  logic signed [PosW-1:0] pos_in;
  logic [ElapsedW-1:0]    elapsed_inc;
  logic                   stopped;
  logic                   step;
  logic                   neg;
  logic signed [PosW:0]   diff;
  logic [PosW:0]          abs_diff;
  logic                   near;
  logic [IntervalW-1:0]   ramp_gap;
  logic [IntervalW-1:0]   ramp_down;

  assign cmd    = cmd_e'(command_i);
  assign pos_in = (position_i == PosMostNeg) ? PosNegLimit : position_i;

  assign stopped     = (pos_now_q == pos_goal_q);
  assign elapsed_inc = (&elapsed_q) ? elapsed_q : elapsed_q + 1'b1;
  assign step        = (cmd == CMD_TICK) && !stopped && (elapsed_inc > {1'b0, ramp_q});
  assign neg         = (pos_now_q > pos_goal_q);
  assign diff        = {pos_now_q[PosW-1], pos_now_q} - {pos_goal_q[PosW-1], pos_goal_q};
  assign abs_diff    = diff[PosW] ? -diff : diff;
  // distance after the step is one less than before it
  assign near        = (abs_diff <= NearDistance);
  assign ramp_gap    = ramp_q - step_interval_q;

  always_comb begin
    if (ramp_q > step_interval_q) begin
      ramp_down = (ramp_gap < RampDownStep) ? step_interval_q : ramp_q - RampDownStep;
    end else begin
      ramp_down = step_interval_q;
    end
  end

  always_comb begin
    pos_now_d  = pos_now_q;
    pos_goal_d = pos_goal_q;
    ramp_d     = ramp_q;
    elapsed_d  = elapsed_q;
    last_dir_d = last_dir_q;
    unique case (cmd)
      CMD_TICK: begin
        elapsed_d = elapsed_inc;
        if (step) begin
          elapsed_d  = '0;
          last_dir_d = neg;
          pos_now_d  = neg ? pos_now_q - PosW'(1) : pos_now_q + PosW'(1);
          ramp_d     = (near && ramp_down < SlowCeiling) ? ramp_down + SlowUpStep : ramp_down;
        end
      end
      CMD_GOTO: begin
        pos_goal_d = pos_in;
        if (stopped) begin
          ramp_d = RampStart;
        end
      end
      CMD_STOP: begin
        pos_goal_d = pos_now_q;
      end
      CMD_SET: begin
        pos_now_d = pos_in;
        if (stopped) begin
          pos_goal_d = pos_in;
        end
      end
      default: ;
    endcase
  end

  assign result_o.step_taken       = step;
  assign result_o.move_negative    = step & neg;
  assign result_o.dir_pin_level    = last_dir_d ^ invert_q;
  assign result_o.current_position = pos_now_d;
  assign result_o.target_position  = pos_goal_d;
  assign result_o.moving           = (pos_now_d != pos_goal_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_interval_q <= IntervalRst;
      invert_q        <= 1'b0;
    end else if (cfg_i.we) begin
      unique case (cfg_i.index)
        REG_STEP_INTERVAL: step_interval_q <= cfg_i.data;
        REG_INVERT:        invert_q        <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_now_q  <= '0;
      pos_goal_q <= '0;
      ramp_q     <= RampStart;
      elapsed_q  <= '0;
      last_dir_q <= 1'b0;
    end else if (accept_i) begin
      pos_now_q  <= pos_now_d;
      pos_goal_q <= pos_goal_d;
      ramp_q     <= ramp_d;
      elapsed_q  <= elapsed_d;
      last_dir_q <= last_dir_d;
    end
  end

`ifndef SYNTH
  a_step_restarts_timer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && step |=> elapsed_q == '0)
    else $error("elapsed counter not cleared after a step");

  a_step_only_when_moving: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |-> pos_now_q != pos_goal_q)
    else $error("step issued at target");

  a_stop_halts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && cmd == CMD_STOP |=> pos_now_q == pos_goal_q)
    else $error("stop left the axis moving");
`endif

endmodule
`default_nettype wire

// ----- design/srpc_out_buf.sv -----
// Two-entry output buffer (result register plus skid register).
`default_nettype none
module srpc_out_buf (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire srpc_pkg::result_t data_i,
  output logic                   ready_o,
  output logic                   valid_o,
  input  wire logic              pop_ready_i,
  output srpc_pkg::result_t      data_o
);
  import srpc_pkg::*;

  result_t main_q, skid_q;
  logic    main_valid_q, skid_valid_q;
  logic    pop;

  assign ready_o = !skid_valid_q;
  assign valid_o = main_valid_q;
  assign data_o  = main_q;
  assign pop     = main_valid_q && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (pop && skid_valid_q) begin
      skid_valid_q <= 1'b0;
    end else if (pop || !main_valid_q) begin
      main_valid_q <= push_i;
    end else if (push_i) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop && skid_valid_q) begin
      main_q <= skid_q;
    end else if (pop || !main_valid_q) begin
      main_q <= data_i;
    end else if (push_i) begin
      skid_q <= data_i;
    end
  end

`ifndef SYNTH
  a_skid_behind_main: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> main_valid_q)
    else $error("skid entry held without a result entry");

  a_stall_fills_skid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && main_valid_q && !pop_ready_i |=> skid_valid_q)
    else $error("item dropped while output stalled");

  a_skid_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && skid_valid_q |=> !skid_valid_q && main_valid_q)
    else $error("skid entry not moved to output");
`endif

endmodule
`default_nettype wire
